/* sv/sstfs_pkg.sv */
// shared types and codes of the session slot table with focus stack
package sstfs_pkg;

	// request command codes
	typedef enum logic [2:0] {
		CMD_CREATE    = 3'd0,
		CMD_ENABLE    = 3'd1,
		CMD_DESTROY   = 3'd2,
		CMD_LOOKUP    = 3'd3,
		CMD_QUERY_TOP = 3'd4
	} cmd_e_t;

	// response status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_e_t;

	// sequencer states
	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SEARCH,
		FSM_APPLY
	} fsm_state_t;

	// request payload
	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] owner_id;
		logic [2:0]  slot;
	} req_t;

	// response payload
	typedef struct packed {
		logic [1:0] status;
		logic [2:0] slot_out;
		logic       on_top;
	} rsp_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic search;
		logic apply;
	} ctrl_t;

	// status from datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

/* sv/sstfs_chan_if.sv */
// valid/ready channel carrying one payload type
interface sstfs_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* sv/sstfs_ctrl.sv */
// sequencer: capture, search and apply steps for each request
module sstfs_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  sstfs_pkg::dp_status_t   stat,
	output sstfs_pkg::ctrl_t        ctrl
);
	import sstfs_pkg::*;

	fsm_state_t state_q;
	fsm_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		ctrl      = '0;
		case (state_q)
			FSM_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctrl.capture = 1'b1;
					state_d      = FSM_SEARCH;
				end
			end
			FSM_SEARCH: begin
				ctrl.search = 1'b1;
				state_d     = FSM_APPLY;
			end
			FSM_APPLY: begin
				// finish once the output register can take the response
				if (stat.out_free) begin
					ctrl.apply = 1'b1;
					req_ready  = 1'b1;
					if (req_valid) begin
						ctrl.capture = 1'b1;
						state_d      = FSM_SEARCH;
					end else begin
						state_d = FSM_IDLE;
					end
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

endmodule

/* sv/sstfs_datapath.sv */
// slot table, focus stack, search registers and response register
module sstfs_datapath #(
	parameter int SLOTS      = 8,
	parameter int OWNER_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sstfs_pkg::ctrl_t        ctrl,
	output sstfs_pkg::dp_status_t   stat,
	input  sstfs_pkg::req_t         req_data,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output sstfs_pkg::rsp_t         rsp_data
);
	import sstfs_pkg::*;

	localparam int SW = $clog2(SLOTS);

	// captured request
	logic [2:0]            cmd_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [2:0]            slot_q;
	logic [OWNER_BITS+15:0] owner_wide;

	// table and stack
	logic [OWNER_BITS-1:0] slot_owner_q [SLOTS];
	logic [SLOTS-1:0]      slot_used_q;
	logic [SW-1:0]         stack_entry_q [SLOTS];
	logic [SLOTS-1:0]      stack_valid_q;

	logic [OWNER_BITS-1:0] slot_owner_d [SLOTS];
	logic [SLOTS-1:0]      slot_used_d;
	logic [SW-1:0]         stack_entry_d [SLOTS];
	logic [SLOTS-1:0]      stack_valid_d;

	// search results
	logic          slot_ok;
	logic [SW+2:0] slot_wide;
	logic [SW-1:0] slot_idx;
	logic          free_hit;
	logic [SW-1:0] free_idx;
	logic          look_hit;
	logic [SW-1:0] look_idx;
	logic          pos_hit;
	logic [SW-1:0] pos_idx;
	logic [SW-1:0] ins_idx;

	logic          slot_ok_s1;
	logic [SW-1:0] slot_idx_s1;
	logic          free_hit_s1;
	logic [SW-1:0] free_idx_s1;
	logic          look_hit_s1;
	logic [SW-1:0] look_idx_s1;
	logic          pos_hit_s1;
	logic [SW-1:0] move_pos_s1;
	logic          full_s1;

	// response
	logic [SW+2:0] free_wide;
	logic [SW+2:0] look_wide;
	rsp_t          res;
	rsp_t          rsp_data_q;
	logic          rsp_valid_q;

	// owner id kept in its low bits
	assign owner_wide = {{OWNER_BITS{1'b0}}, req_data.owner_id};

	// request capture
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q   <= req_data.cmd;
			owner_q <= owner_wide[OWNER_BITS-1:0];
			slot_q  <= req_data.slot;
		end
	end

	// slot number range check and table index
	assign slot_ok   = int'(slot_q) < SLOTS;
	assign slot_wide = {{SW{1'b0}}, slot_q};
	assign slot_idx  = slot_wide[SW-1:0];

	// parallel compares with lowest-index priority
	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		look_hit = 1'b0;
		look_idx = '0;
		pos_hit  = 1'b0;
		pos_idx  = '0;
		ins_idx  = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!slot_used_q[i]) begin
				free_hit = 1'b1;
				free_idx = SW'(i);
			end
			if (slot_used_q[i] && slot_owner_q[i] == owner_q) begin
				look_hit = 1'b1;
				look_idx = SW'(i);
			end
			if (stack_valid_q[i] && stack_entry_q[i] == slot_idx) begin
				pos_hit = 1'b1;
				pos_idx = SW'(i);
			end
			if (!stack_valid_q[i]) begin
				ins_idx = SW'(i);
			end
		end
	end

	// search result registers
	always_ff @(posedge clk) begin
		if (ctrl.search) begin
			slot_ok_s1  <= slot_ok;
			slot_idx_s1 <= slot_idx;
			free_hit_s1 <= free_hit;
			free_idx_s1 <= free_idx;
			look_hit_s1 <= look_hit;
			look_idx_s1 <= look_idx;
			pos_hit_s1  <= pos_hit;
			move_pos_s1 <= pos_hit ? pos_idx : ins_idx;
			full_s1     <= stack_valid_q[SLOTS-1];
		end
	end

	// slot numbers onto the 3-bit response field
	assign free_wide = {3'b000, free_idx_s1};
	assign look_wide = {3'b000, look_idx_s1};

	// update of table and stack, and the response
	always_comb begin
		slot_owner_d  = slot_owner_q;
		slot_used_d   = slot_used_q;
		stack_entry_d = stack_entry_q;
		stack_valid_d = stack_valid_q;
		res           = '0;
		res.status    = ST_OK;
		case (cmd_q)
			CMD_CREATE: begin
				if (free_hit_s1) begin
					res.slot_out = free_wide[2:0];
					for (int i = 0; i < SLOTS; i++) begin
						if (free_idx_s1 == SW'(i)) begin
							slot_used_d[i]  = 1'b1;
							slot_owner_d[i] = owner_q;
						end
					end
				end else begin
					res.status = ST_FULL;
				end
			end
			CMD_ENABLE: begin
				if (slot_ok_s1) begin
					if (!pos_hit_s1 && full_s1) begin
						res.status = ST_FULL;
					end else begin
						// entries ahead of the move position slide down one place
						for (int i = 1; i < SLOTS; i++) begin
							if (i <= int'(move_pos_s1)) begin
								stack_entry_d[i] = stack_entry_q[i-1];
								stack_valid_d[i] = stack_valid_q[i-1];
							end
						end
						stack_entry_d[0] = slot_idx_s1;
						stack_valid_d[0] = 1'b1;
					end
				end
			end
			CMD_DESTROY: begin
				if (slot_ok_s1) begin
					// later entries move up to close the gap
					if (pos_hit_s1) begin
						for (int i = 0; i < SLOTS - 1; i++) begin
							if (i >= int'(move_pos_s1)) begin
								stack_entry_d[i] = stack_entry_q[i+1];
								stack_valid_d[i] = stack_valid_q[i+1];
							end
						end
						stack_entry_d[SLOTS-1] = '0;
						stack_valid_d[SLOTS-1] = 1'b0;
					end
					for (int i = 0; i < SLOTS; i++) begin
						if (slot_idx_s1 == SW'(i)) begin
							slot_used_d[i]  = 1'b0;
							slot_owner_d[i] = '0;
						end
					end
				end
			end
			CMD_LOOKUP: begin
				if (look_hit_s1) begin
					res.slot_out = look_wide[2:0];
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			CMD_QUERY_TOP: begin
				res.on_top = slot_ok_s1 && stack_valid_q[0] &&
					stack_entry_q[0] == slot_idx_s1;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// table and stack registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_used_q   <= '0;
			stack_valid_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_owner_q[i]  <= '0;
				stack_entry_q[i] <= '0;
			end
		end else if (ctrl.apply) begin
			slot_used_q   <= slot_used_d;
			stack_valid_q <= stack_valid_d;
			slot_owner_q  <= slot_owner_d;
			stack_entry_q <= stack_entry_d;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.apply) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.apply) begin
			rsp_data_q <= res;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign rsp_data      = rsp_data_q;
	assign stat.out_free = !rsp_valid_q || rsp_ready;

endmodule

/* sv/session_slot_table_with_focus_stack_core.sv */
// Session slot table with a most-recent-first focus stack. Each request on req
// (create, enable, destroy, lookup, query top) gives exactly one response on rsp.
// A request passes a search step, which registers the parallel table and stack
// compares, and then an apply step, which applies the update and loads the
// response register; the next request may already be accepted with the apply
// step. A response left waiting in the output register holds the apply step
// until it is taken.
// Reset clears the table and the stack at once, with no sweep.
module session_slot_table_with_focus_stack_core #(
	parameter int SLOTS      = 8,
	parameter int OWNER_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	sstfs_chan_if.sink   req,
	sstfs_chan_if.source rsp
);
	import sstfs_pkg::*;

	ctrl_t      ctrl;
	dp_status_t stat;

	// sequencer
	sstfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// table, stack and response
	sstfs_datapath #(
		.SLOTS      (SLOTS),
		.OWNER_BITS (OWNER_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.req_data  (req.data),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data)
	);

endmodule

/* sv/sstfs_checker.sv */
// port-level checks of the session slot table core, bound to the top level
module sstfs_port_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input sstfs_pkg::rsp_t rsp_data
);
	import sstfs_pkg::*;

	// a waiting response stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before it was taken");

	// a waiting response keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("response payload changed while stalled");

	// the search cycle after an accepted request takes no new request
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted during search cycle");

	// a fresh response traces back to an accepted request, through search and apply
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
		else $error("response without a matching request");

endmodule

bind session_slot_table_with_focus_stack_core sstfs_port_checker u_sstfs_port_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
